@@ rtl/dtb_pkg.sv @@
// shared types and constants of the dual thrust breakout signal block
package dtb_pkg;

    localparam int DTB_MAX_WINDOW = 64;
    localparam int DTB_PRICE_BITS = 32;
    localparam int DTB_BAND_W     = 48;
    localparam int DTB_GAIN_W     = 16;
    localparam int DTB_GAIN_FRAC  = 12;
    localparam int DTB_WIN_W      = 7;
    localparam int DTB_CFG_IDX_W  = 2;
    localparam int DTB_QTY_W      = 8;
    localparam int DTB_LOT_STOCK  = 100;
    localparam int DTB_LOTS       = 2;

    localparam logic [DTB_WIN_W-1:0]  DTB_WIN_RST  = 7'd20;
    localparam logic [DTB_GAIN_W-1:0] DTB_GAIN_RST = 16'd2048;

    // configuration register indexes
    localparam logic [DTB_CFG_IDX_W-1:0] DTB_REG_WINDOW = 2'd0;
    localparam logic [DTB_CFG_IDX_W-1:0] DTB_REG_UGAIN  = 2'd1;
    localparam logic [DTB_CFG_IDX_W-1:0] DTB_REG_LGAIN  = 2'd2;
    localparam logic [DTB_CFG_IDX_W-1:0] DTB_REG_STOCK  = 2'd3;

    // position side codes
    localparam logic [1:0] DTB_SIDE_FLAT  = 2'd0;
    localparam logic [1:0] DTB_SIDE_LONG  = 2'd1;
    localparam logic [1:0] DTB_SIDE_SHORT = 2'd2;

    typedef enum logic [2:0] {
        ACT_NONE        = 3'd0,
        ACT_ENTER_LONG  = 3'd1,
        ACT_ENTER_SHORT = 3'd2,
        ACT_EXIT_LONG   = 3'd3,
        ACT_EXIT_SHORT  = 3'd4
    } t_action;

    // chain control: shift a new bar in, or rotate the ring by one
    typedef struct packed {
        logic shift;
        logic rotate;
    } t_cell_ctl;

endpackage

@@ rtl/dtb_bar_if.sv @@
// input channel: one closed price bar and the held position side
interface dtb_bar_if
    import dtb_pkg::*;
#(
    parameter int PRICE_BITS = DTB_PRICE_BITS
);
    logic                  valid;
    logic                  ready;
    logic [PRICE_BITS-1:0] bar_open;
    logic [PRICE_BITS-1:0] bar_high;
    logic [PRICE_BITS-1:0] bar_low;
    logic [PRICE_BITS-1:0] bar_close;
    logic [1:0]            position_side;

    modport source (output valid, bar_open, bar_high, bar_low, bar_close, position_side,
                    input ready);
    modport sink   (input valid, bar_open, bar_high, bar_low, bar_close, position_side,
                    output ready);
endinterface

@@ rtl/dtb_sig_if.sv @@
// output channel: trade action, order size and breakout bands
interface dtb_sig_if
    import dtb_pkg::*;
();
    logic                         valid;
    logic                         ready;
    logic [2:0]                   action;
    logic [DTB_QTY_W-1:0]         order_qty;
    logic signed [DTB_BAND_W-1:0] upper_band;
    logic signed [DTB_BAND_W-1:0] lower_band;
    logic                         bands_valid;

    modport source (output valid, action, order_qty, upper_band, lower_band, bands_valid,
                    input ready);
    modport sink   (input valid, action, order_qty, upper_band, lower_band, bands_valid,
                    output ready);
endinterface

@@ rtl/dtb_cell.sv @@
// one bar slot of the ring: loads from the previous cell on shift, the next on rotate
module dtb_cell
    import dtb_pkg::*;
#(
    parameter int PRICE_BITS = DTB_PRICE_BITS
) (
    input  logic                  i_clk,
    input  t_cell_ctl             i_ctl,
    input  logic [PRICE_BITS-1:0] i_prev_high,
    input  logic [PRICE_BITS-1:0] i_prev_low,
    input  logic [PRICE_BITS-1:0] i_prev_close,
    input  logic [PRICE_BITS-1:0] i_next_high,
    input  logic [PRICE_BITS-1:0] i_next_low,
    input  logic [PRICE_BITS-1:0] i_next_close,
    output logic [PRICE_BITS-1:0] o_high,
    output logic [PRICE_BITS-1:0] o_low,
    output logic [PRICE_BITS-1:0] o_close
);
    logic [PRICE_BITS-1:0] r_high;
    logic [PRICE_BITS-1:0] r_low;
    logic [PRICE_BITS-1:0] r_close;

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_high  <= i_prev_high;
            r_low   <= i_prev_low;
            r_close <= i_prev_close;
        end else if (i_ctl.rotate) begin
            r_high  <= i_next_high;
            r_low   <= i_next_low;
            r_close <= i_next_close;
        end
    end

    assign o_high  = r_high;
    assign o_low   = r_low;
    assign o_close = r_close;
endmodule

@@ rtl/dtb_chain.sv @@
// row of bar cells; cell 0 holds the newest bar, the ring closes for rotation
module dtb_chain
    import dtb_pkg::*;
#(
    parameter int MAX_WINDOW = DTB_MAX_WINDOW,
    parameter int PRICE_BITS = DTB_PRICE_BITS
) (
    input  logic                  i_clk,
    input  t_cell_ctl             i_ctl,
    input  logic [PRICE_BITS-1:0] i_new_high,
    input  logic [PRICE_BITS-1:0] i_new_low,
    input  logic [PRICE_BITS-1:0] i_new_close,
    output logic [PRICE_BITS-1:0] o_head_high,
    output logic [PRICE_BITS-1:0] o_head_low,
    output logic [PRICE_BITS-1:0] o_head_close
);
    logic [PRICE_BITS-1:0] w_high  [MAX_WINDOW];
    logic [PRICE_BITS-1:0] w_low   [MAX_WINDOW];
    logic [PRICE_BITS-1:0] w_close [MAX_WINDOW];

    for (genvar k = 0; k < MAX_WINDOW; k++) begin : g_cell
        localparam int PREV = (k == 0) ? 0 : k - 1;
        localparam int NEXT = (k == MAX_WINDOW - 1) ? 0 : k + 1;
        logic [PRICE_BITS-1:0] w_ph, w_pl, w_pc;

        assign w_ph = (k == 0) ? i_new_high  : w_high[PREV];
        assign w_pl = (k == 0) ? i_new_low   : w_low[PREV];
        assign w_pc = (k == 0) ? i_new_close : w_close[PREV];

        dtb_cell #(
            .PRICE_BITS (PRICE_BITS)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctl        (i_ctl),
            .i_prev_high  (w_ph),
            .i_prev_low   (w_pl),
            .i_prev_close (w_pc),
            .i_next_high  (w_high[NEXT]),
            .i_next_low   (w_low[NEXT]),
            .i_next_close (w_close[NEXT]),
            .o_high       (w_high[k]),
            .o_low        (w_low[k]),
            .o_close      (w_close[k])
        );
    end

    assign o_head_high  = w_high[0];
    assign o_head_low   = w_low[0];
    assign o_head_close = w_close[0];
endmodule

@@ rtl/dual_thrust_breakout_signal.sv @@
// Dual thrust breakout signal. One bar item is taken at a time. After acceptance
// the ring of bar cells rotates once past the head cell, one ring cell per scan
// step, to gather the highest/lowest high, low and close; then come one step for
// the range, two for the band multiplies, one for the lower band and one for the
// decision, which registers the result item. The bar is shifted into the ring
// after the scan. The next bar is taken in the cycle after the result is
// registered, so a bar is never taken while another is in work; a stalled output
// holds the block in its decision step until the waiting result leaves.
// A finished result waits in the output register while the next bar is taken.
// The user must write configuration through i_cfg_* only while the block is
// idle; the block itself does not enforce this.
module dual_thrust_breakout_signal
    import dtb_pkg::*;
#(
    parameter int MAX_WINDOW = DTB_MAX_WINDOW,
    parameter int PRICE_BITS = DTB_PRICE_BITS
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [DTB_CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DTB_GAIN_W-1:0]    i_cfg_data,
    dtb_bar_if.sink                  i_bar,
    dtb_sig_if.source                o_sig
);
    localparam int CW  = (MAX_WINDOW > 2) ? $clog2(MAX_WINDOW) : 1;
    localparam int NW  = $clog2(MAX_WINDOW + 1);
    localparam int RW  = PRICE_BITS + 1;
    localparam int PRW = RW + DTB_GAIN_W + 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RANGE,
        ST_MUL_U,
        ST_MUL_L,
        ST_SUM_L,
        ST_DECIDE
    } t_state;

    t_state r_state;

    logic [DTB_WIN_W-1:0]  r_window;
    logic [DTB_GAIN_W-1:0] r_ugain;
    logic [DTB_GAIN_W-1:0] r_lgain;
    logic                  r_stock;

    logic [CW-1:0] r_cnt;
    logic [NW-1:0] r_bars_seen;
    logic          r_bands_ok;

    logic [PRICE_BITS-1:0] r_open, r_high, r_low, r_close;
    logic [1:0]            r_side;
    logic [PRICE_BITS-1:0] r_hh, r_ll, r_hc, r_lc;
    logic signed [RW-1:0]  r_range;
    logic signed [PRW-1:0] r_prod;
    logic signed [DTB_BAND_W-1:0] r_upper, r_lower;

    logic                         r_out_valid;
    t_action                      r_out_action;
    logic [DTB_QTY_W-1:0]         r_out_qty;
    logic signed [DTB_BAND_W-1:0] r_out_upper, r_out_lower;
    logic                         r_out_bands_ok;

    logic [NW-1:0]         w_need;
    t_cell_ctl             w_ctl;
    logic [PRICE_BITS-1:0] w_head_high, w_head_low, w_head_close;
    logic signed [RW-1:0]  w_r1, w_r2;
    logic signed [PRW-1:0] w_scaled;
    logic signed [DTB_BAND_W-1:0] w_open_ext, w_close_ext;
    t_action               n_action;
    logic                  w_in_acc, w_out_acc, w_out_free;

    // earlier bars needed: window clamped to 2..MAX_WINDOW, less the current bar
    always_comb begin
        if (r_window < DTB_WIN_W'(2)) begin
            w_need = NW'(1);
        end else if (int'(r_window) > MAX_WINDOW) begin
            w_need = NW'(MAX_WINDOW - 1);
        end else begin
            w_need = NW'(r_window - DTB_WIN_W'(1));
        end
    end

    assign w_in_acc   = i_bar.valid && i_bar.ready;
    assign w_out_acc  = r_out_valid && o_sig.ready;
    assign w_out_free = !r_out_valid || o_sig.ready;

    assign w_ctl.rotate = (r_state == ST_SCAN);
    assign w_ctl.shift  = (r_state == ST_MUL_U);

    dtb_chain #(
        .MAX_WINDOW (MAX_WINDOW),
        .PRICE_BITS (PRICE_BITS)
    ) u_chain (
        .i_clk        (i_clk),
        .i_ctl        (w_ctl),
        .i_new_high   (r_high),
        .i_new_low    (r_low),
        .i_new_close  (r_close),
        .o_head_high  (w_head_high),
        .o_head_low   (w_head_low),
        .o_head_close (w_head_close)
    );

    assign w_r1 = $signed({1'b0, r_hh}) - $signed({1'b0, r_lc});
    assign w_r2 = $signed({1'b0, r_hc}) - $signed({1'b0, r_ll});
    // arithmetic shift floors toward minus infinity
    assign w_scaled    = r_prod >>> DTB_GAIN_FRAC;
    assign w_open_ext  = $signed({{(DTB_BAND_W - PRICE_BITS){1'b0}}, r_open});
    assign w_close_ext = $signed({{(DTB_BAND_W - PRICE_BITS){1'b0}}, r_close});

    always_comb begin
        n_action = ACT_NONE;
        unique case (r_side)
            DTB_SIDE_FLAT: begin
                if (w_close_ext >= r_upper) begin
                    n_action = ACT_ENTER_LONG;
                end else if (w_close_ext <= r_lower && !r_stock) begin
                    n_action = ACT_ENTER_SHORT;
                end
            end
            DTB_SIDE_LONG: begin
                if (w_close_ext <= r_lower) begin
                    n_action = ACT_EXIT_LONG;
                end
            end
            DTB_SIDE_SHORT: begin
                if (w_close_ext >= r_upper && !r_stock) begin
                    n_action = ACT_EXIT_SHORT;
                end
            end
            default: n_action = ACT_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window    <= DTB_WIN_RST;
            r_ugain     <= DTB_GAIN_RST;
            r_lgain     <= DTB_GAIN_RST;
            r_stock     <= 1'b0;
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_bars_seen <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    DTB_REG_WINDOW: r_window <= i_cfg_data[DTB_WIN_W-1:0];
                    DTB_REG_UGAIN:  r_ugain  <= i_cfg_data;
                    DTB_REG_LGAIN:  r_lgain  <= i_cfg_data;
                    DTB_REG_STOCK:  r_stock  <= i_cfg_data[0];
                    default: ;
                endcase
            end

            if (w_out_acc) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (w_in_acc) begin
                        r_open     <= i_bar.bar_open;
                        r_high     <= i_bar.bar_high;
                        r_low      <= i_bar.bar_low;
                        r_close    <= i_bar.bar_close;
                        r_side     <= i_bar.position_side;
                        r_bands_ok <= (r_bars_seen >= w_need);
                        r_hh       <= '0;
                        r_hc       <= '0;
                        r_ll       <= '1;
                        r_lc       <= '1;
                        r_cnt      <= '0;
                        r_state    <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    // head cell holds the bar r_cnt+1 steps back
                    if (NW'(r_cnt) < w_need) begin
                        if (w_head_high > r_hh)   r_hh <= w_head_high;
                        if (w_head_low < r_ll)    r_ll <= w_head_low;
                        if (w_head_close > r_hc)  r_hc <= w_head_close;
                        if (w_head_close < r_lc)  r_lc <= w_head_close;
                    end
                    if (r_cnt == CW'(MAX_WINDOW - 1)) begin
                        r_cnt   <= '0;
                        r_state <= ST_RANGE;
                    end else begin
                        r_cnt <= r_cnt + CW'(1);
                    end
                end
                ST_RANGE: begin
                    r_range <= (w_r1 > w_r2) ? w_r1 : w_r2;
                    r_state <= ST_MUL_U;
                end
                ST_MUL_U: begin
                    r_prod <= PRW'($signed({1'b0, r_ugain})) * PRW'(r_range);
                    if (int'(r_bars_seen) < MAX_WINDOW) begin
                        r_bars_seen <= r_bars_seen + NW'(1);
                    end
                    r_state <= ST_MUL_L;
                end
                ST_MUL_L: begin
                    r_upper <= w_open_ext + DTB_BAND_W'(w_scaled);
                    r_prod  <= PRW'($signed({1'b0, r_lgain})) * PRW'(r_range);
                    r_state <= ST_SUM_L;
                end
                ST_SUM_L: begin
                    r_lower <= w_open_ext - DTB_BAND_W'(w_scaled);
                    r_state <= ST_DECIDE;
                end
                ST_DECIDE: begin
                    if (w_out_free) begin
                        r_out_valid    <= 1'b1;
                        r_out_bands_ok <= r_bands_ok;
                        if (r_bands_ok) begin
                            r_out_action <= n_action;
                            r_out_upper  <= r_upper;
                            r_out_lower  <= r_lower;
                            if (n_action == ACT_NONE) begin
                                r_out_qty <= '0;
                            end else if (r_stock) begin
                                r_out_qty <= DTB_QTY_W'(DTB_LOTS * DTB_LOT_STOCK);
                            end else begin
                                r_out_qty <= DTB_QTY_W'(DTB_LOTS);
                            end
                        end else begin
                            r_out_action <= ACT_NONE;
                            r_out_qty    <= '0;
                            r_out_upper  <= '0;
                            r_out_lower  <= '0;
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign i_bar.ready       = (r_state == ST_IDLE);
    assign o_sig.valid       = r_out_valid;
    assign o_sig.action      = r_out_action;
    assign o_sig.order_qty   = r_out_qty;
    assign o_sig.upper_band  = r_out_upper;
    assign o_sig.lower_band  = r_out_lower;
    assign o_sig.bands_valid = r_out_bands_ok;

`ifndef SYNTHESIS
    a_cnt_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_SCAN) |-> (r_cnt == '0))
        else $error("scan counter not parked outside the scan");

    a_bars_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_bars_seen) <= MAX_WINDOW)
        else $error("stored bar count beyond ring depth");

    a_acc_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state == ST_SCAN))
        else $error("accepted item did not start a scan");

    a_one_insert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MUL_U && int'(r_bars_seen) < MAX_WINDOW)
            |=> (r_bars_seen == $past(r_bars_seen) + NW'(1)))
        else $error("bar insert not counted");

    a_no_qty_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_action == ACT_NONE) |-> (r_out_qty == '0))
        else $error("order size given without an action");
`endif
endmodule
